// ===== rtl/bpf_pkg.sv =====
// ============================================================================
// Bezier path follower package
// Shared constants, register indexes and transaction payload types.
// ============================================================================
package bpf_pkg;

  // Coordinate width of one axis and number of control points supported.
  localparam int COORD_WIDTH = 16;
  localparam int MAX_POINTS  = 6;

  // Bits of one packed control point (x, y, z).
  localparam int PT_BITS   = 3 * COORD_WIDTH;
  // Coordinate queue used by the reduction: three entries per point.
  localparam int QLEN      = 3 * MAX_POINTS;
  localparam int QL_W      = $clog2(QLEN + 1);
  localparam int LD_W      = $clog2(MAX_POINTS);

  // Configuration port.
  localparam int NUM_REGS  = 7;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_POINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_FOUR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_FIVE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DUR     = 3'd6;

  // Field widths and fixed-point constants.
  localparam int ELAPSED_W = 16;
  localparam int INVDUR_W  = 16;
  localparam int PROG_W    = 17;
  localparam logic [PROG_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [PROG_W-1:0] PROG_MAX = 17'h1FFFF;
  localparam int ROUND_HALF = 32768;

  // Input item kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [ELAPSED_W-1:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic                          finished;
  } out_item_t;

endpackage

// ===== rtl/bezier_path_follower_core.sv =====
// ============================================================================
// Bezier path follower core
// Advances a Q1.16 progress value per tick and evaluates a Bezier curve of up
// to six 3D control points by de Casteljau reduction on one shared lerp unit.
// ============================================================================
// Usage:
//   Control points and the inverse duration are to be written on the cfg_
//   port only while the block is idle; the block does not enforce this.
//   Each input transaction is a time tick or a stop; each produces exactly
//   one output transaction carrying a position or the finished flag.
//   A stop, a tick with no path, or a tick after the path has ended gives a
//   finished result without a control point scan or reduction.
//   A tick scans every control point register and keeps the points in use
//   (start point plus non-zero points), then reduces them pass by pass on
//   the single lerp unit, which computes one coordinate per cycle; each
//   pass ends with a step that drops the last point of the previous level.
//   in_ready is high only while no item is in progress; one item is handled
//   at a time. The result sits in an output register, so a new item is taken
//   while the previous result still waits for out_ready; a stalled receiver
//   holds the block only when a second result is ready to be written.
//   Synchronous active-low reset clears progress, the configuration registers
//   and any pending transaction.
// ============================================================================
module bezier_path_follower_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bpf_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bpf_pkg::out_item_t               out_data,
  input  logic                             cfg_wr_en,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpf_pkg::CFG_W-1:0]        cfg_wdata
);
  import bpf_pkg::*;

  localparam int W = COORD_WIDTH;

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK   = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_REDUCE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // Configuration registers.
  logic [PT_BITS-1:0]  pts_cfg_r [MAX_POINTS];
  logic [INVDUR_W-1:0] inv_dur_r;

  // Control state.
  logic [2:0]        state_r, state_nxt;
  logic [PROG_W-1:0] progress_r, progress_nxt;
  logic [LD_W-1:0]   ld_idx_r, ld_idx_nxt;
  logic [QL_W-1:0]   q_len_r, q_len_nxt;
  logic [QL_W-1:0]   pass_cnt_r, pass_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [PROG_W-1:0]     t_r, t_nxt;
  logic signed [W-1:0]   q_r [QLEN];
  logic signed [W-1:0]   q_nxt [QLEN];
  out_item_t             res_r, res_nxt;
  out_item_t             out_r, out_nxt;

  // Datapath signals.
  logic [2*ELAPSED_W-1:0] inc_prod;
  logic [PROG_W+7:0]      prog_sum;
  logic [PROG_W-1:0]      prog_sat;
  logic [PT_BITS-1:0]     ld_pt;
  logic                   ld_keep;
  logic signed [W:0]      lerp_diff;
  logic signed [PROG_W:0] lerp_t;
  logic signed [W+18:0]   lerp_prod;
  logic signed [W+18:0]   lerp_rnd;
  logic signed [W-1:0]    lerp_res;
  logic [QL_W-1:0]        wr_idx;
  logic                   finish_now;
  logic                   out_free;

  // Progress increment: (elapsed * inverse duration) >> 8, saturating add.
  always_comb begin
    inc_prod = elapsed_r * inv_dur_r;
    prog_sum = {8'd0, progress_r} + {{(PROG_W+8-(2*ELAPSED_W-8)){1'b0}},
                                     inc_prod[2*ELAPSED_W-1:8]};
    if (prog_sum > {8'd0, PROG_MAX}) begin
      prog_sat = PROG_MAX;
    end else begin
      prog_sat = prog_sum[PROG_W-1:0];
    end
  end

  // Shared lerp unit: a + round((b - a) * t / 65536), rounding half up.
  always_comb begin
    lerp_diff = {q_r[3][W-1], q_r[3]} - {q_r[0][W-1], q_r[0]};
    lerp_t    = signed'({1'b0, t_r});
    lerp_prod = lerp_diff * lerp_t;
    lerp_rnd  = lerp_prod + (W+19)'(ROUND_HALF);
    lerp_res  = q_r[0] + lerp_rnd[W+15:16];
  end

  // Control point scan.
  always_comb begin
    ld_pt   = pts_cfg_r[ld_idx_r];
    ld_keep = (ld_idx_r == '0) || (ld_pt != '0);
  end

  assign wr_idx     = q_len_r - QL_W'(1);
  assign finish_now = (in_data.kind == KIND_STOP) || (inv_dur_r == '0) ||
                      (progress_r > ONE_Q16);
  assign out_free   = !out_valid_r || out_ready;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    progress_nxt  = progress_r;
    ld_idx_nxt    = ld_idx_r;
    q_len_nxt     = q_len_r;
    pass_cnt_nxt  = pass_cnt_r;
    out_valid_nxt = out_valid_r;
    elapsed_nxt   = elapsed_r;
    t_nxt         = t_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    for (int k = 0; k < QLEN; k++) begin
      q_nxt[k] = q_r[k];
    end

    // The output register empties when the receiver takes the transaction.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (finish_now) begin
            progress_nxt      = '0;
            res_nxt.pos_x     = '0;
            res_nxt.pos_y     = '0;
            res_nxt.pos_z     = '0;
            res_nxt.finished  = 1'b1;
            state_nxt         = S_DONE;
          end else begin
            elapsed_nxt = in_data.elapsed;
            state_nxt   = S_TICK;
          end
        end
      end
      S_TICK: begin
        progress_nxt = prog_sat;
        t_nxt        = (prog_sat > ONE_Q16) ? ONE_Q16 : prog_sat;
        ld_idx_nxt   = LD_W'(MAX_POINTS - 1);
        q_len_nxt    = '0;
        state_nxt    = S_LOAD;
      end
      S_LOAD: begin
        // Points are pushed at the head in reverse order, so the queue ends
        // up holding the used points in their original order.
        if (ld_keep) begin
          for (int k = 3; k < QLEN; k++) begin
            q_nxt[k] = q_r[k-3];
          end
          q_nxt[0]  = ld_pt[W-1:0];
          q_nxt[1]  = ld_pt[2*W-1:W];
          q_nxt[2]  = ld_pt[3*W-1:2*W];
          q_len_nxt = q_len_r + QL_W'(3);
        end
        if (ld_idx_r == '0) begin
          pass_cnt_nxt = ld_keep ? q_len_r + QL_W'(3) : q_len_r;
          state_nxt    = S_REDUCE;
        end else begin
          ld_idx_nxt = ld_idx_r - LD_W'(1);
        end
      end
      S_REDUCE: begin
        if (q_len_r == QL_W'(3)) begin
          // One point left: that is the curve position.
          res_nxt.pos_x    = q_r[0];
          res_nxt.pos_y    = q_r[1];
          res_nxt.pos_z    = q_r[2];
          res_nxt.finished = 1'b0;
          state_nxt        = S_DONE;
        end else if (pass_cnt_r == QL_W'(3)) begin
          // End of a pass: drop the last point of the previous level.
          for (int k = 0; k < QLEN - 3; k++) begin
            q_nxt[k] = q_r[k+3];
          end
          q_len_nxt    = q_len_r - QL_W'(3);
          pass_cnt_nxt = q_len_r - QL_W'(3);
        end else begin
          // Consume the head coordinate and append its lerp at the tail.
          for (int k = 0; k < QLEN - 1; k++) begin
            q_nxt[k] = q_r[k+1];
          end
          for (int k = 0; k < QLEN; k++) begin
            if (QL_W'(k) == wr_idx) begin
              q_nxt[k] = lerp_res;
            end
          end
          pass_cnt_nxt = pass_cnt_r - QL_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      progress_r  <= '0;
      ld_idx_r    <= '0;
      q_len_r     <= '0;
      pass_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      inv_dur_r   <= '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        pts_cfg_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      progress_r  <= progress_nxt;
      ld_idx_r    <= ld_idx_nxt;
      q_len_r     <= q_len_nxt;
      pass_cnt_r  <= pass_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        if (cfg_index == REG_INV_DUR) begin
          inv_dur_r <= cfg_wdata[INVDUR_W-1:0];
        end
        for (int i = 0; i < MAX_POINTS; i++) begin
          if (cfg_index == CFG_IDX_W'(i)) begin
            pts_cfg_r[i] <= PT_BITS'({{PT_BITS{1'b0}}, cfg_wdata});
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    t_r       <= t_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    for (int k = 0; k < QLEN; k++) begin
      q_r[k] <= q_nxt[k];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
